// File: rtl/b64sc_pkg.sv
package b64sc_pkg;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        KIND_ENC = 2'd0,
        KIND_DEC = 2'd1,
        KIND_BAD = 2'd2
    } t_kind;

    // cnt: bytes held (1..3) for an encode group, final byte index for a decode group
    typedef struct packed {
        t_kind       kind;
        logic        last;
        logic [1:0]  cnt;
        logic [23:0] bits;
    } t_job;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return 8'h41 + w;
        end else if (v < 6'd52) begin
            return 8'h61 + (w - 8'd26);
        end else if (v < 6'd62) begin
            return 8'h30 + (w - 8'd52);
        end else if (v == 6'd62) begin
            return 8'h2B;
        end
        return 8'h2F;
    endfunction

    // Anything outside the alphabet maps to zero
    function automatic logic [5:0] dec_sextet(input logic [7:0] c);
        logic [7:0] w;
        w = 8'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            w = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            w = c - 8'h61 + 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            w = c - 8'h30 + 8'd52;
        end else if (c == 8'h2B) begin
            w = 8'd62;
        end else if (c == 8'h2F) begin
            w = 8'd63;
        end
        return w[5:0];
    endfunction

endpackage

// File: rtl/base64_stream_codec_unit.sv
// Streaming base64 codec. Write the mode register (0 encode, 1 decode) only while the
// block is idle; a write drops any partial group. The front end takes one word every cycle
// while the four-entry group queue has room and gathers groups; the back end emits one
// result word per cycle from its output register while the receiver is ready. Encoding is
// therefore bound by the back end at four characters per three bytes, decoding runs at
// one character per cycle. The first result of a group passes through the group queue, the
// job register and the output register. A decode message ending inside a group yields one
// word with data zero, tlast and tuser set.
module base64_stream_codec_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser    // [0] bad_length
);
    import b64sc_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_job push_job;
    t_job head_job;

    b64sc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .i_byte        (i_s_axis_tdata),
        .i_last        (i_s_axis_tlast),
        .i_q_full      (q_full),
        .o_ready       (o_s_axis_tready),
        .o_push        (q_push),
        .o_job         (push_job)
    );

    b64sc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    b64sc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_pop     (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_byte    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast),
        .o_bad     (o_m_axis_tuser)
    );

endmodule

// File: rtl/b64sc_front.sv
module b64sc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    input  logic               i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output b64sc_pkg::t_job    o_job
);
    import b64sc_pkg::*;

    logic        r_mode;
    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  r_pad, n_pad;
    logic        accept;
    logic [4:0]  shamt;
    logic [1:0]  take_m1;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_bits  = r_bits;
        n_cnt   = r_cnt;
        n_pad   = r_pad;
        o_push  = 1'b0;
        o_job   = '0;
        shamt   = 5'd0;
        take_m1 = 2'd0;
        if (i_cfg_wr_en) begin
            n_bits = '0;
            n_cnt  = '0;
            n_pad  = '0;
        end else if (accept) begin
            if (!r_mode) begin
                n_bits = r_bits | ({i_byte, 16'b0} >> {r_cnt, 3'b000});
                if (r_cnt == 2'd2 || i_last) begin
                    o_push     = 1'b1;
                    o_job.kind = KIND_ENC;
                    o_job.last = i_last;
                    o_job.cnt  = r_cnt + 2'd1;
                    o_job.bits = n_bits;
                    n_bits     = '0;
                    n_cnt      = '0;
                    n_pad      = '0;
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end else begin
                case (r_cnt)
                    2'd0:    shamt = 5'd0;
                    2'd1:    shamt = 5'd6;
                    2'd2:    shamt = 5'd12;
                    default: shamt = 5'd18;
                endcase
                if (r_cnt == 2'd2 && i_byte == PAD_CHAR) begin
                    n_pad = r_pad | 2'b10;
                end else if (r_cnt == 2'd3 && i_byte == PAD_CHAR) begin
                    n_pad = r_pad | 2'b01;
                end else begin
                    n_bits = r_bits | ({dec_sextet(i_byte), 18'b0} >> shamt);
                end
                if (r_cnt != 2'd3) begin
                    if (i_last) begin
                        // message ended inside a group
                        o_push     = 1'b1;
                        o_job.kind = KIND_BAD;
                        o_job.last = 1'b1;
                        n_bits     = '0;
                        n_cnt      = '0;
                        n_pad      = '0;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end else begin
                    if (n_pad[1]) begin
                        take_m1 = 2'd0;
                    end else if (n_pad[0]) begin
                        take_m1 = 2'd1;
                    end else begin
                        take_m1 = 2'd2;
                    end
                    o_push     = 1'b1;
                    o_job.kind = KIND_DEC;
                    o_job.last = i_last;
                    o_job.cnt  = take_m1;
                    o_job.bits = n_bits;
                    n_bits     = '0;
                    n_cnt      = '0;
                    n_pad      = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_bits <= '0;
            r_cnt  <= '0;
            r_pad  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
            r_pad  <= n_pad;
        end
    end

endmodule

// File: rtl/b64sc_fifo.sv
module b64sc_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  b64sc_pkg::t_job    i_job,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_empty,
    output b64sc_pkg::t_job    o_job
);
    import b64sc_pkg::*;

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (Q_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (Q_AW+1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("group queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("group queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("group queue count out of range");

endmodule

// File: rtl/b64sc_back.sv
module b64sc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  b64sc_pkg::t_job    i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_byte,
    output logic               o_last,
    output logic               o_bad
);
    import b64sc_pkg::*;

    t_job        r_job;
    logic        r_busy;
    logic [1:0]  r_idx;
    logic        r_ov;
    logic [7:0]  r_byte;
    logic        r_last;
    logic        r_bad;

    logic        can_emit;
    logic        emit;
    logic        done;
    logic [1:0]  fin;
    logic [5:0]  sx;
    logic [7:0]  res_byte;
    logic        res_last;
    logic        res_bad;

    always_comb begin
        case (r_job.kind)
            KIND_ENC: fin = 2'd3;
            KIND_DEC: fin = r_job.cnt;
            default:  fin = 2'd0;
        endcase
    end

    assign can_emit = !r_ov || i_ready;
    assign emit     = r_busy && can_emit;
    assign done     = (r_idx == fin);
    assign o_pop    = !i_q_empty && (!r_busy || (emit && done));

    always_comb begin
        case (r_idx)
            2'd0:    sx = r_job.bits[23:18];
            2'd1:    sx = r_job.bits[17:12];
            2'd2:    sx = r_job.bits[11:6];
            default: sx = r_job.bits[5:0];
        endcase
        res_byte = 8'd0;
        res_last = 1'b0;
        res_bad  = 1'b0;
        case (r_job.kind)
            KIND_ENC: begin
                res_byte = (r_idx <= r_job.cnt) ? enc_char(sx) : PAD_CHAR;
                res_last = r_job.last && done;
            end
            KIND_DEC: begin
                case (r_idx)
                    2'd0:    res_byte = r_job.bits[23:16];
                    2'd1:    res_byte = r_job.bits[15:8];
                    default: res_byte = r_job.bits[7:0];
                endcase
                res_last = r_job.last && done;
            end
            default: begin
                res_last = 1'b1;
                res_bad  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= res_byte;
            r_last <= res_last;
            r_bad  <= res_bad;
        end
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (emit && done) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_byte;
    assign o_last  = r_last;
    assign o_bad   = r_bad;

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_bad) |-> (r_last && r_byte == 8'd0))
        else $error("length error word not closing the message");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= fin))
        else $error("result index past end of group");

endmodule

// File: dv/tb_base64_stream_codec_unit.sv
`timescale 1ns / 100ps

module tb_base64_stream_codec_unit;

    import b64sc_pkg::*;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;
    localparam string B64_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_out_word;

    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_wr_en     = 1'b0;
    logic       i_cfg_wr_data   = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata  = 8'h00;
    logic       i_s_axis_tlast  = 1'b0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;
    logic       o_m_axis_tuser;

    bit idle_on = 1'b1;
    int items_sent = 0;

    base64_stream_codec_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    class b64_scoreboard;
        logic        mode;
        logic [23:0] grp_bits;
        int          grp_cnt;
        logic [1:0]  pad_flags;
        t_out_word   pending[$];
        int          fail_count;

        function new();
            mode       = MODE_ENC;
            fail_count = 0;
            clear_group();
        endfunction

        function void clear_group();
            grp_bits  = 24'h0;
            grp_cnt   = 0;
            pad_flags = 2'b00;
        endfunction

        function void set_mode(logic m);
            mode = m;
            clear_group();
        endfunction

        function void push_out(logic [7:0] d, logic l, logic b);
            t_out_word w;
            w.data = d;
            w.last = l;
            w.bad  = b;
            pending.push_back(w);
        endfunction

        function void note_word(logic [7:0] d, logic l);
            logic [23:0] wide;
            logic [5:0]  six;
            int          held;
            int          take;
            wide = {16'h0, d};
            if (mode == MODE_ENC) begin
                grp_bits = grp_bits | (wide << (16 - 8 * grp_cnt));
                held = grp_cnt + 1;
                if (held < 3 && !l) begin
                    grp_cnt = held;
                    return;
                end
                for (int j = 0; j < 4; j++) begin
                    six = 6'((grp_bits >> (18 - 6 * j)) & 24'h3F);
                    push_out((j <= held) ? B64_SET[six] : PAD_CHAR, l && j == 3, 1'b0);
                end
                clear_group();
            end else begin
                // '=' only counts as padding in the last two positions of a group
                if (grp_cnt == 2 && d == PAD_CHAR) begin
                    pad_flags[1] = 1'b1;
                end else if (grp_cnt == 3 && d == PAD_CHAR) begin
                    pad_flags[0] = 1'b1;
                end else begin
                    six = 6'd0;
                    if (d >= "A" && d <= "Z") six = 6'(d - 8'h41);
                    else if (d >= "a" && d <= "z") six = 6'(d - 8'h61 + 8'd26);
                    else if (d >= "0" && d <= "9") six = 6'(d - 8'h30 + 8'd52);
                    else if (d == "+") six = 6'd62;
                    else if (d == "/") six = 6'd63;
                    grp_bits = grp_bits | ({18'h0, six} << (18 - 6 * grp_cnt));
                end
                if (grp_cnt < 3) begin
                    if (l) begin
                        push_out(8'h00, 1'b1, 1'b1);
                        clear_group();
                    end else begin
                        grp_cnt++;
                    end
                    return;
                end
                take = pad_flags[1] ? 1 : (pad_flags[0] ? 2 : 3);
                for (int j = 0; j < take; j++)
                    push_out(8'((grp_bits >> (16 - 8 * j)) & 24'hFF), l && j + 1 == take, 1'b0);
                clear_group();
            end
        endfunction

        function void check_word(logic [7:0] d, logic l, logic b);
            t_out_word want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word, expected none, got data %02h last %0b bad %0b",
                         $time, d, l, b);
                fail_count++;
                return;
            end
            want = pending.pop_front();
            if (want.data !== d) begin
                $display("%0t: data mismatch, expected %02h, got %02h", $time, want.data, d);
                fail_count++;
            end
            if (want.last !== l) begin
                $display("%0t: tlast mismatch, expected %0b, got %0b", $time, want.last, l);
                fail_count++;
            end
            if (want.bad !== b) begin
                $display("%0t: bad_length mismatch, expected %0b, got %0b", $time, want.bad, b);
                fail_count++;
            end
        endfunction
    endclass

    b64_scoreboard sb = new();

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // handshakes sampled mid-cycle, where every signal is settled
    always @(negedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            sb.note_word(i_s_axis_tdata, i_s_axis_tlast);
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_word(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= idle_on ? ($urandom_range(99) >= 29) : 1'b1;
    end

    task automatic send_byte(input logic [7:0] d, input logic l);
        bit took;
        if (idle_on && $urandom_range(99) < 29) begin
            do begin
                i_s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end while ($urandom_range(99) < 40);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= d;
        i_s_axis_tlast  <= l;
        do begin
            @(negedge i_clk);
            took = o_s_axis_tready;
            @(posedge i_clk);
        end while (!took);
        items_sent++;
    endtask

    task automatic send_msg(input logic [7:0] words[$], input bit close);
        foreach (words[i])
            send_byte(words[i], close && i == words.size() - 1);
    endtask

    task automatic write_mode(input logic m);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        // a trailing partial group may still be in flight
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_mode(m);
    endtask

    task automatic send_random_encode();
        logic [7:0] words[$];
        int len;
        len = $urandom_range(1, 10);
        repeat (len) words.push_back(8'($urandom_range(255)));
        send_msg(words, 1'b1);
    endtask

    task automatic send_random_decode();
        logic [7:0] words[$];
        int groups;
        int pads;
        int total;
        logic [7:0] c;
        groups = $urandom_range(1, 4);
        pads   = $urandom_range(0, 2);
        total  = groups * 4;
        for (int i = 0; i < total; i++) begin
            c = B64_SET[$urandom_range(63)];
            if (i >= total - pads) c = PAD_CHAR;
            if ($urandom_range(99) < 6) c = 8'($urandom_range(255));
            else if ($urandom_range(99) < 4) c = PAD_CHAR;
            words.push_back(c);
        end
        // truncated message now and then
        if ($urandom_range(99) < 12) total = $urandom_range(1, total - 1);
        while (words.size() > total) void'(words.pop_back());
        send_msg(words, 1'b1);
    endtask

    initial begin
        logic [7:0] words[$];
        int start;
        logic m;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(MODE_ENC);
        words = '{8'h4D, 8'h61};
        send_msg(words, 1'b1);
        words = '{8'hFF};
        send_msg(words, 1'b1);
        words = '{8'h00, 8'hFF, 8'h80};
        send_msg(words, 1'b1);

        write_mode(MODE_DEC);
        // padding in the third slot, then a group straight after it
        words = '{"Q", "U", "=", "x"};
        send_msg(words, 1'b0);
        words = '{"+", "/", "9", "z"};
        send_msg(words, 1'b1);
        words = '{"=", 8'h00, 8'hFF};
        send_msg(words, 1'b1);
        words = '{"T", "W", "E", "="};
        send_msg(words, 1'b1);
        words = '{"A"};
        send_msg(words, 1'b1);

        for (int phase = 0; phase < 8; phase++) begin
            idle_on = !(phase == 3 || phase == 4);
            m = (phase % 2) ? MODE_DEC : MODE_ENC;
            write_mode(m);
            start = items_sent;
            while (items_sent - start < 50) begin
                if (m == MODE_ENC) send_random_encode();
                else send_random_decode();
            end
            // leave a partial group for the mode write to drop
            if ($urandom_range(1)) begin
                words.delete();
                repeat ($urandom_range(1, 2)) words.push_back(8'($urandom_range(255)));
                send_msg(words, 1'b0);
            end
        end
        idle_on = 1'b1;
        write_mode(MODE_ENC);

        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: base64_stream_codec_unit.f
rtl/b64sc_pkg.sv
rtl/b64sc_front.sv
rtl/b64sc_fifo.sv
rtl/b64sc_back.sv
rtl/base64_stream_codec_unit.sv
dv/tb_base64_stream_codec_unit.sv
